FILE: src/lss_pkg.sv
// shared types and constants for the lifo stack with key search
// no dependencies; used by every module of the block
package lss_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int OP_W = 2;
  localparam int KEY_W = 8;
  localparam int NUM_W = 32;
  localparam int VAL_W = 64;
  localparam int DEP_W = 4;
  localparam int DEPTH_MAX = 15;

  // queue geometry, used by the command and result queues
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // operation codes on the input port
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // classified command kind
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_SEARCH,
    CMD_NONE
  } cmd_kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SRCH
  } back_state_t;

  // command from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [KEY_W-1:0]  key;
    logic [NUM_W-1:0]  number;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NUM_W-1:0]  number;
    logic [VAL_W-1:0]  value;
    logic              hit;
    logic [DEP_W-1:0]  depth;
    logic              overflow;
  } res_t;

  // saturate a scan depth to the reported field width
  function automatic logic [DEP_W-1:0] sat_depth(input logic [PTR_W-1:0] d);
    logic [31:0] wide;
    wide = 32'(d);
    if (wide > 32'(DEPTH_MAX)) begin
      return DEP_W'(DEPTH_MAX);
    end
    return DEP_W'(d);
  endfunction

endpackage

FILE: src/lss_front.sv
// front end: accepts input transactions, classifies the op code
// and buffers commands in a short queue; depends on lss_pkg
module lss_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [lss_pkg::OP_W-1:0]    in_op,
  input  logic [lss_pkg::KEY_W-1:0]   in_key_char,
  input  logic [lss_pkg::NUM_W-1:0]   in_number_in,
  input  logic [lss_pkg::VAL_W-1:0]   in_value_bits_in,
  output logic                        cmd_valid,
  output lss_pkg::cmd_t               cmd,
  input  logic                        cmd_take
);

  lss_pkg::cmd_t                  q_mem_r [lss_pkg::Q_DEPTH];
  logic [lss_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lss_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lss_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           accept;
  lss_pkg::cmd_t                  new_cmd;

  assign full = (cnt_r == lss_pkg::Q_CNT_W'(lss_pkg::Q_DEPTH));
  assign accept = push && !full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_mem_r[rd_ptr_r];

  // classify the op code
  always_comb begin
    new_cmd.key = in_key_char;
    new_cmd.number = in_number_in;
    new_cmd.value = in_value_bits_in;
    case (in_op)
      lss_pkg::OP_PUSH:   new_cmd.kind = lss_pkg::CMD_PUSH;
      lss_pkg::OP_POP:    new_cmd.kind = lss_pkg::CMD_POP;
      lss_pkg::OP_SEARCH: new_cmd.kind = lss_pkg::CMD_SEARCH;
      default:            new_cmd.kind = lss_pkg::CMD_NONE;
    endcase
  end

  // queue pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_take) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (accept && !cmd_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && cmd_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: src/lss_back.sv
// back end: holds the stack memories and sequences push, pop and
// the top-down key scan; depends on lss_pkg
module lss_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  lss_pkg::cmd_t  cmd,
  output logic           cmd_take,
  input  logic           res_room,
  output logic           res_valid,
  output lss_pkg::res_t  res
);

  logic [lss_pkg::KEY_W-1:0]  key_mem [lss_pkg::STACK_DEPTH];
  logic [lss_pkg::NUM_W-1:0]  num_mem [lss_pkg::STACK_DEPTH];
  logic [lss_pkg::VAL_W-1:0]  val_mem [lss_pkg::STACK_DEPTH];

  lss_pkg::back_state_t       st_r, st_nxt;
  logic [lss_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [lss_pkg::PTR_W-1:0]  idx_r, idx_nxt;
  logic [lss_pkg::PTR_W-1:0]  depth_r, depth_nxt;
  logic [lss_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lss_pkg::KEY_W-1:0]  key_rd_r;
  logic [lss_pkg::NUM_W-1:0]  num_rd_r;
  logic [lss_pkg::VAL_W-1:0]  val_rd_r;
  logic [lss_pkg::PTR_W-1:0]  rd_addr;
  logic [lss_pkg::PTR_W-1:0]  wr_addr;
  logic [lss_pkg::PTR_W-1:0]  top;
  logic                       wr_en;
  logic                       is_full;

  assign top = lss_pkg::PTR_W'(fill_r - 1'b1);
  assign wr_addr = lss_pkg::PTR_W'(fill_r);
  assign is_full = (fill_r == lss_pkg::CNT_W'(lss_pkg::STACK_DEPTH));

  // sequencer next state and outputs
  always_comb begin
    st_nxt = st_r;
    fill_nxt = fill_r;
    idx_nxt = idx_r;
    depth_nxt = depth_r;
    key_nxt = key_r;
    cmd_take = 1'b0;
    res_valid = 1'b0;
    res = '0;
    wr_en = 1'b0;
    rd_addr = top;
    case (st_r)
      lss_pkg::ST_IDLE: begin
        if (cmd_valid && res_room) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            lss_pkg::CMD_PUSH: begin
              res_valid = 1'b1;
              if (is_full) begin
                res.overflow = 1'b1;
              end else begin
                wr_en = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            lss_pkg::CMD_POP: begin
              if (fill_r == '0) begin
                res_valid = 1'b1;
              end else begin
                fill_nxt = fill_r - 1'b1;
                st_nxt = lss_pkg::ST_POP;
              end
            end
            lss_pkg::CMD_SEARCH: begin
              if (fill_r == '0) begin
                res_valid = 1'b1;
              end else begin
                key_nxt = cmd.key;
                idx_nxt = top;
                depth_nxt = '0;
                st_nxt = lss_pkg::ST_SRCH;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      lss_pkg::ST_POP: begin
        res_valid = 1'b1;
        res.key = key_rd_r;
        res.number = num_rd_r;
        res.value = val_rd_r;
        res.hit = 1'b1;
        st_nxt = lss_pkg::ST_IDLE;
      end
      lss_pkg::ST_SRCH: begin
        // key of slot idx_r is in key_rd_r; fetch the next one down
        rd_addr = idx_r - 1'b1;
        if (key_rd_r == key_r) begin
          res_valid = 1'b1;
          res.hit = 1'b1;
          res.depth = lss_pkg::sat_depth(depth_r);
          st_nxt = lss_pkg::ST_IDLE;
        end else if (idx_r == '0) begin
          res_valid = 1'b1;
          st_nxt = lss_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
      default: begin
        st_nxt = lss_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lss_pkg::ST_IDLE;
      fill_r <= '0;
    end else begin
      st_r <= st_nxt;
      fill_r <= fill_nxt;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    depth_r <= depth_nxt;
    key_r <= key_nxt;
  end

  // stack memories, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= cmd.key;
      num_mem[wr_addr] <= cmd.number;
      val_mem[wr_addr] <= cmd.value;
    end
    key_rd_r <= key_mem[rd_addr];
    num_rd_r <= num_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
  end

`ifndef SYNTHESIS
  // fill level never passes the stack depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lss_pkg::CNT_W'(lss_pkg::STACK_DEPTH))
    else $error("fill level beyond stack depth");

  // the scan stays inside the stored entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lss_pkg::ST_SRCH) |-> (lss_pkg::CNT_W'(idx_r) < fill_r))
    else $error("scan index outside stored entries");

  // a stored push grows the stack by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && cmd.kind == lss_pkg::CMD_PUSH && !is_full)
      |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("push did not grow the stack");

  // a result is only produced when the result queue has room
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_room)
    else $error("result with no room in result queue");
`endif

endmodule

FILE: src/lss_outq.sv
// result queue: buffers result transactions toward the output port
// depends on lss_pkg
module lss_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_valid,
  input  lss_pkg::res_t                res,
  output logic                         res_room,
  input  logic                         pop,
  output logic                         empty,
  output logic [lss_pkg::KEY_W-1:0]    out_key_out,
  output logic signed [lss_pkg::NUM_W-1:0] out_number_out,
  output logic [lss_pkg::VAL_W-1:0]    out_value_bits_out,
  output logic                         out_hit,
  output logic [lss_pkg::DEP_W-1:0]    out_match_depth,
  output logic                         out_overflow
);

  lss_pkg::res_t                  q_mem_r [lss_pkg::Q_DEPTH];
  logic [lss_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lss_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lss_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           deq;
  lss_pkg::res_t                  head;

  assign res_room = (cnt_r != lss_pkg::Q_CNT_W'(lss_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign deq = pop && !empty;
  assign head = q_mem_r[rd_ptr_r];

  // unpack the head entry onto the ports
  assign out_key_out = head.key;
  assign out_number_out = head.number;
  assign out_value_bits_out = head.value;
  assign out_hit = head.hit;
  assign out_match_depth = head.depth;
  assign out_overflow = head.overflow;

  // queue pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (res_valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (res_valid && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!res_valid && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

FILE: src/lifo_stack_with_search.sv
// lifo stack with key search: usage
// input channel: an op (push, pop, search), a key and a payload enter as one
// transaction when push is high and full is low. op code 3 does nothing but
// still gives a result of all zeros.
// result channel: one result per input transaction, in order; it is on the
// out_ ports while empty is low and leaves when pop is high.
// the back end handles one transaction at a time; a search walks the key
// memory from the top down, one key per cycle, and stops at the first
// match or after the bottom entry.
// a two-entry command queue and a two-entry result queue let input and
// output stall independently; a stalled receiver fills the result queue,
// then the back end waits, then full rises.
// reset (synchronous, active low) empties both queues and the stack.
// depends on lss_pkg, lss_front, lss_back, lss_outq
module lifo_stack_with_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [lss_pkg::OP_W-1:0]         in_op,
  input  logic [lss_pkg::KEY_W-1:0]        in_key_char,
  input  logic signed [lss_pkg::NUM_W-1:0] in_number_in,
  input  logic [lss_pkg::VAL_W-1:0]        in_value_bits_in,
  output logic                             empty,
  input  logic                             pop,
  output logic [lss_pkg::KEY_W-1:0]        out_key_out,
  output logic signed [lss_pkg::NUM_W-1:0] out_number_out,
  output logic [lss_pkg::VAL_W-1:0]        out_value_bits_out,
  output logic                             out_hit,
  output logic [lss_pkg::DEP_W-1:0]        out_match_depth,
  output logic                             out_overflow
);

  logic           cmd_valid;
  logic           cmd_take;
  lss_pkg::cmd_t  cmd;
  logic           res_valid;
  logic           res_room;
  lss_pkg::res_t  res;

  // accept and classify
  lss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_key_char      (in_key_char),
    .in_number_in     (in_number_in),
    .in_value_bits_in (in_value_bits_in),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take)
  );

  // stack and scan sequencer
  lss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_room  (res_room),
    .res_valid (res_valid),
    .res       (res)
  );

  // result buffering
  lss_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res_valid),
    .res                (res),
    .res_room           (res_room),
    .pop                (pop),
    .empty              (empty),
    .out_key_out        (out_key_out),
    .out_number_out     (out_number_out),
    .out_value_bits_out (out_value_bits_out),
    .out_hit            (out_hit),
    .out_match_depth    (out_match_depth),
    .out_overflow       (out_overflow)
  );

endmodule
